// ----- rtl/chip8_core_with_sprite_draw_core_defines.svh -----
// Assertion macros used by the CHIP-8 core.
`ifndef CHIP8_CORE_WITH_SPRITE_DRAW_CORE_DEFINES_SVH
`define CHIP8_CORE_WITH_SPRITE_DRAW_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define C8SD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c8sd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define C8SD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c8sd: next-cycle check failed");

`endif

// ----- rtl/c8sd_pkg.sv -----
// Shared constants, codes and beat types of the CHIP-8 core.
`timescale 1ns / 1ps

package c8sd_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int NUM_REGS      = 16;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int RIDX_W = $clog2(NUM_REGS);

    // Item operations
    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD = 2'd0;
    localparam op_t OP_EXEC = 2'd1;
    localparam op_t OP_ROW  = 2'd2;

    // Opcode classes (top nibble)
    typedef logic [3:0] opc_t;
    localparam opc_t OPC_SYS   = 4'h0;
    localparam opc_t OPC_JUMP  = 4'h1;
    localparam opc_t OPC_SET   = 4'h6;
    localparam opc_t OPC_ADD   = 4'h7;
    localparam opc_t OPC_INDEX = 4'hA;
    localparam opc_t OPC_DRAW  = 4'hD;

    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [RIDX_W-1:0] REG_VF = RIDX_W'(NUM_REGS - 1);

    typedef struct packed {
        op_t               operation;
        logic [15:0]       instruction;
        logic [ADDR_W-1:0] load_address;
        logic [7:0]        load_byte;
        logic [ROW_W-1:0]  row_select;
    } c8sd_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]       pc_value;
        logic [ADDR_W-1:0]       index_value;
        logic [7:0]              register_value;
        logic                    collision;
        logic                    unknown_opcode;
        logic [SCREEN_WIDTH-1:0] row_pixels;
    } c8sd_rsp_t;

endpackage

// ----- rtl/c8sd_if.sv -----
// Valid/ready channel interfaces for the request and response beats.
`timescale 1ns / 1ps

interface c8sd_req_if import c8sd_pkg::*; ();
    logic      valid;
    logic      ready;
    c8sd_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c8sd_rsp_if import c8sd_pkg::*; ();
    logic      valid;
    logic      ready;
    c8sd_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/chip8_core_with_sprite_draw_core.sv -----
// Top level of the CHIP-8 instruction subset core with sprite draw.
//
//   channel | dir | beat contents
//   --------+-----+----------------------------------------------------------
//   req     | in  | operation, instruction, load_address, load_byte, row_select
//   rsp     | out | pc_value, index_value, register_value, collision,
//           |     | unknown_opcode, row_pixels
//
// Any operation but DXYN goes through DECODE and FINISH to the
// response; DXYN adds DRAW_Y, DRAW_ROW and DRAW_FLAG (only DRAW_FLAG when N is 0),
// one sprite row per cycle through the single program-memory and display-row ports.
// Reset (rst_n low, asynchronous) clears the registers, sets PC to 0x200 and
// marks every display row unlit at once through per-row valid bits.
// req.ready is high only while idle; a finished response waits in its output register.
`timescale 1ns / 1ps
`include "chip8_core_with_sprite_draw_core_defines.svh"

module chip8_core_with_sprite_draw_core import c8sd_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    c8sd_req_if.sink     req,
    c8sd_rsp_if.source   rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DRAW_Y,
        ST_DRAW_ROW,
        ST_DRAW_FLAG,
        ST_FINISH
    } state_t;

    localparam logic [ADDR_W-1:0] PC_RESET = ADDR_W'(512);

    // Sequencer and architectural state
    state_t                  state_reg, state_next;
    c8sd_req_t               item_reg, item_next;
    logic [ADDR_W-1:0]       pc_reg, pc_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic [7:0]              vreg_reg [NUM_REGS];
    logic [7:0]              vreg_next [NUM_REGS];
    logic                    unk_reg, unk_next;
    logic [SCREEN_WIDTH-1:0] row_pix_reg, row_pix_next;

    // Draw loop state
    logic [COL_W-1:0]        sx_reg, sx_next;
    logic [ROW_W:0]          cur_y_reg, cur_y_next;
    logic [ADDR_W-1:0]       mem_ptr_reg, mem_ptr_next;
    logic [3:0]              row_cnt_reg, row_cnt_next;
    logic                    flag_reg, flag_next;

    // Display row valid bits and registered read side
    logic [SCREEN_HEIGHT-1:0] frame_vld_reg, frame_vld_next;
    logic                     frame_vld_q_reg, frame_vld_q_next;

    // Response output register
    logic                    rsp_valid_reg, rsp_valid_next;
    c8sd_rsp_t               rsp_data_reg, rsp_data_next;

    // Memories
    logic [7:0]              prog_mem [MEM_BYTES];
    logic [7:0]              mem_q_reg;
    logic [ADDR_W-1:0]       mem_raddr;
    logic                    mem_we;

    logic [SCREEN_WIDTH-1:0] frame_mem [SCREEN_HEIGHT];
    logic [SCREEN_WIDTH-1:0] frame_q_reg;
    logic [ROW_W-1:0]        frame_raddr;
    logic                    frame_we;
    logic [SCREEN_WIDTH-1:0] frame_wdata;

    // Decoded fields
    logic [15:0]             ins;
    logic [3:0]              opc;
    logic [RIDX_W-1:0]       rx, ry;
    logic [7:0]              nn;
    logic [3:0]              n;

    // Register file read port and draw datapath
    logic [RIDX_W-1:0]       rf_raddr;
    logic [7:0]              rf_rdata;
    logic [ROW_W:0]          cur_y_inc;
    logic [SCREEN_WIDTH-1:0] sprite_mask;
    logic [SCREEN_WIDTH-1:0] old_row;
    logic                    row_on;

    assign ins = item_reg.instruction;
    assign opc = ins[15:12];
    assign rx  = ins[11:8];
    assign ry  = ins[7:4];
    assign nn  = ins[7:0];
    assign n   = ins[3:0];

    // One register-file read port: Y while fetching the draw origin, X otherwise
    assign rf_raddr = (state_reg == ST_DRAW_Y) ? ry : rx;
    assign rf_rdata = vreg_reg[rf_raddr];

    assign cur_y_inc = cur_y_reg + (ROW_W + 1)'(1);

    // Place the sprite byte at column sx; bits past the right edge fall off
    assign sprite_mask = {mem_q_reg, {(SCREEN_WIDTH - 8){1'b0}}} >> sx_reg;
    assign old_row     = frame_vld_q_reg ? frame_q_reg : '0;
    assign row_on      = !cur_y_reg[ROW_W];
    assign frame_wdata = old_row ^ sprite_mask;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Read addresses: the row select is sampled while idle so the row is
    // ready in DECODE; the draw loop prefetches the next row each cycle.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   frame_raddr = req.data.row_select;
            ST_DRAW_Y: frame_raddr = rf_rdata[ROW_W-1:0];
            default:   frame_raddr = cur_y_inc[ROW_W-1:0];
        endcase
        mem_raddr = (state_reg == ST_DRAW_Y) ? idx_reg : mem_ptr_reg + ADDR_W'(1);
    end

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        pc_next          = pc_reg;
        idx_next         = idx_reg;
        vreg_next        = vreg_reg;
        unk_next         = unk_reg;
        row_pix_next     = row_pix_reg;
        sx_next          = sx_reg;
        cur_y_next       = cur_y_reg;
        mem_ptr_next     = mem_ptr_reg;
        row_cnt_next     = row_cnt_reg;
        flag_next        = flag_reg;
        frame_vld_next   = frame_vld_reg;
        frame_vld_q_next = frame_vld_reg[frame_raddr];
        rsp_data_next    = rsp_data_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        mem_we           = 1'b0;
        frame_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    item_next    = req.data;
                    unk_next     = 1'b0;
                    row_pix_next = '0;
                    state_next   = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_FINISH;
                unique case (item_reg.operation)
                    OP_LOAD: mem_we = 1'b1;
                    OP_ROW:  row_pix_next = old_row;
                    OP_EXEC:
                    begin
                        unique case (opc)
                            OPC_SYS:
                            begin
                                if (ins == INS_CLS)
                                    frame_vld_next = '0;
                                else
                                    unk_next = 1'b1;
                            end
                            OPC_JUMP:  pc_next = ins[ADDR_W-1:0];
                            OPC_SET:   vreg_next[rx] = nn;
                            OPC_ADD:   vreg_next[rx] = rf_rdata + nn;
                            OPC_INDEX: idx_next = ins[ADDR_W-1:0];
                            OPC_DRAW:
                            begin
                                sx_next    = rf_rdata[COL_W-1:0];
                                flag_next  = 1'b0;
                                state_next = (n == 4'd0) ? ST_DRAW_FLAG : ST_DRAW_Y;
                            end
                            default:   unk_next = 1'b1;
                        endcase
                    end
                    default: ;
                endcase
            end

            ST_DRAW_Y:
            begin
                // Latch the row origin; first sprite byte and row are in flight
                cur_y_next   = {1'b0, rf_rdata[ROW_W-1:0]};
                mem_ptr_next = idx_reg;
                row_cnt_next = 4'd0;
                state_next   = ST_DRAW_ROW;
            end

            ST_DRAW_ROW:
            begin
                // XOR one row in, skip rows below the bottom edge
                if (row_on)
                begin
                    frame_we                                 = 1'b1;
                    frame_vld_next[cur_y_reg[ROW_W-1:0]]     = 1'b1;
                    if (|(old_row & sprite_mask))
                        flag_next = 1'b1;
                end
                cur_y_next   = cur_y_inc;
                mem_ptr_next = mem_ptr_reg + ADDR_W'(1);
                row_cnt_next = row_cnt_reg + 4'd1;
                if (row_cnt_reg == n - 4'd1)
                    state_next = ST_DRAW_FLAG;
            end

            ST_DRAW_FLAG:
            begin
                vreg_next[REG_VF] = {7'd0, flag_reg};
                state_next        = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Hold here only while an earlier beat still waits downstream
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_data_next.pc_value       = pc_reg;
                    rsp_data_next.index_value    = idx_reg;
                    rsp_data_next.register_value =
                        (item_reg.operation == OP_EXEC) ? rf_rdata : 8'd0;
                    rsp_data_next.collision      = vreg_reg[REG_VF][0];
                    rsp_data_next.unknown_opcode = unk_reg;
                    rsp_data_next.row_pixels     = row_pix_reg;
                    state_next                   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            item_reg        <= '0;
            pc_reg          <= PC_RESET;
            idx_reg         <= '0;
            vreg_reg        <= '{default: '0};
            unk_reg         <= 1'b0;
            row_pix_reg     <= '0;
            sx_reg          <= '0;
            cur_y_reg       <= '0;
            mem_ptr_reg     <= '0;
            row_cnt_reg     <= '0;
            flag_reg        <= 1'b0;
            frame_vld_reg   <= '0;
            frame_vld_q_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            item_reg        <= item_next;
            pc_reg          <= pc_next;
            idx_reg         <= idx_next;
            vreg_reg        <= vreg_next;
            unk_reg         <= unk_next;
            row_pix_reg     <= row_pix_next;
            sx_reg          <= sx_next;
            cur_y_reg       <= cur_y_next;
            mem_ptr_reg     <= mem_ptr_next;
            row_cnt_reg     <= row_cnt_next;
            flag_reg        <= flag_next;
            frame_vld_reg   <= frame_vld_next;
            frame_vld_q_reg <= frame_vld_q_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_data_reg    <= rsp_data_next;
        end
    end

    // Program memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            prog_mem[item_reg.load_address] <= item_reg.load_byte;
        mem_q_reg <= prog_mem[mem_raddr];
    end

    // Display rows: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (frame_we)
            frame_mem[cur_y_reg[ROW_W-1:0]] <= frame_wdata;
        frame_q_reg <= frame_mem[frame_raddr];
    end

    `C8SD_ASSERT_NEXT(a_accept_to_decode, req.valid && req.ready, state_reg == ST_DECODE)
    `C8SD_ASSERT_IMPL(a_rsp_from_finish, $rose(rsp_valid_reg), $past(state_reg) == ST_FINISH)
    `C8SD_ASSERT_IMPL(a_row_in_range, state_reg == ST_DRAW_ROW, row_cnt_reg < n)
    `C8SD_ASSERT_NEXT(a_flag_is_bit, state_reg == ST_DRAW_FLAG, vreg_reg[REG_VF][7:1] == 7'd0)

endmodule

// ----- tb/tb_chip8_core_with_sprite_draw_core.sv -----
// Self-checking testbench for the CHIP-8 subset core with sprite draw.
`timescale 1ns / 1ps

module tb_chip8_core_with_sprite_draw_core;
    import c8sd_pkg::*;

    // Operation code that the core ignores; it still answers with one beat.
    localparam op_t OP_IGNORED = 2'd3;

    // Opcode classes outside the subset, used to provoke the unknown flag.
    localparam opc_t OPC_SKIP_EQ_REG = 4'h5;
    localparam opc_t OPC_MISC        = 4'hF;
    localparam logic [15:0] INS_RET  = 16'h00EE;

    // Length of the long receiver hold-off, in cycles.
    localparam int RSP_HOLD_CYCLES = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    c8sd_req_if req_ch ();
    c8sd_rsp_if rsp_ch ();

    chip8_core_with_sprite_draw_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 20 ns period: low half, then high half.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the core state, advanced once per accepted request.
    // ------------------------------------------------------------------
    logic [7:0]              shadow_mem [MEM_BYTES];
    bit                      mem_loaded [MEM_BYTES];
    logic [7:0]              shadow_v   [NUM_REGS];
    logic [ADDR_W-1:0]       shadow_i;
    logic [ADDR_W-1:0]       shadow_pc;
    logic [SCREEN_WIDTH-1:0] shadow_fb  [SCREEN_HEIGHT];

    // Responses the core still owes, oldest first.
    c8sd_rsp_t pending_rsp [$];
    c8sd_rsp_t rsp_want;
    c8sd_rsp_t rsp_got;

    int unsigned beats_sent  = 0;
    int          mismatches  = 0;
    bit          idling_on   = 1'b1;
    bit          hold_rsp_req = 1'b0;
    int          stall_left  = 0;

    // Advance the shadow state by one request beat and return the response
    // that the core must produce for it.
    function automatic c8sd_rsp_t chip8_predict(input c8sd_req_t beat);
        c8sd_rsp_t         r;
        logic [3:0]        xi;
        logic [3:0]        yi;
        logic [7:0]        nn;
        logic [7:0]        bits;
        logic [ADDR_W-1:0] addr;
        int                sx;
        int                sy;
        int                yy;
        int                xx;
        logic              hit;
        r  = '0;
        xi = beat.instruction[11:8];
        yi = beat.instruction[7:4];
        nn = beat.instruction[7:0];
        case (beat.operation)
            OP_LOAD:
            begin
                shadow_mem[beat.load_address] = beat.load_byte;
                mem_loaded[beat.load_address] = 1'b1;
            end
            OP_ROW:
            begin
                r.row_pixels = shadow_fb[beat.row_select];
            end
            OP_EXEC:
            begin
                case (beat.instruction[15:12])
                    OPC_SYS:
                    begin
                        if (beat.instruction == INS_CLS)
                        begin
                            for (int k = 0; k < SCREEN_HEIGHT; k++)
                            begin
                                shadow_fb[k] = '0;
                            end
                        end
                        else
                        begin
                            r.unknown_opcode = 1'b1;
                        end
                    end
                    OPC_JUMP:  shadow_pc = beat.instruction[11:0];
                    OPC_SET:   shadow_v[xi] = nn;
                    OPC_ADD:   shadow_v[xi] = shadow_v[xi] + nn;
                    OPC_INDEX: shadow_i = beat.instruction[11:0];
                    OPC_DRAW:
                    begin
                        // Take the start point before VF is overwritten.
                        sx  = shadow_v[xi] % SCREEN_WIDTH;
                        sy  = shadow_v[yi] % SCREEN_HEIGHT;
                        hit = 1'b0;
                        for (int k = 0; k < beat.instruction[3:0]; k++)
                        begin
                            yy   = sy + k;
                            addr = ADDR_W'(shadow_i + k);
                            bits = shadow_mem[addr];
                            if (yy < SCREEN_HEIGHT)
                            begin
                                for (int c = 0; c < 8; c++)
                                begin
                                    xx = sx + c;
                                    if (bits[7-c] && xx < SCREEN_WIDTH)
                                    begin
                                        if (shadow_fb[yy][63-xx])
                                            hit = 1'b1;
                                        shadow_fb[yy][63-xx] = ~shadow_fb[yy][63-xx];
                                    end
                                end
                            end
                        end
                        shadow_v[REG_VF] = {7'd0, hit};
                    end
                    default: r.unknown_opcode = 1'b1;
                endcase
                r.register_value = shadow_v[xi];
            end
            default: ;
        endcase
        r.pc_value    = shadow_pc;
        r.index_value = shadow_i;
        r.collision   = shadow_v[REG_VF][0];
        return r;
    endfunction

    // Largest row count not above n whose sprite bytes were all loaded.
    function automatic int safe_rows(input int n);
        for (int k = 0; k < n; k++)
        begin
            if (!mem_loaded[ADDR_W'(shadow_i + k)])
                return k;
        end
        return n;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Every field random; builders below overwrite what the operation uses.
    function automatic c8sd_req_t rand_beat();
        c8sd_req_t b;
        b.operation    = op_t'($urandom_range(0, 3));
        b.instruction  = 16'($urandom);
        b.load_address = ADDR_W'($urandom);
        b.load_byte    = 8'($urandom);
        b.row_select   = ROW_W'($urandom);
        return b;
    endfunction

    function automatic c8sd_req_t mk_load(input logic [ADDR_W-1:0] addr,
                                          input logic [7:0] value);
        c8sd_req_t b;
        b              = rand_beat();
        b.operation    = OP_LOAD;
        b.load_address = addr;
        b.load_byte    = value;
        return b;
    endfunction

    function automatic c8sd_req_t mk_exec(input logic [15:0] ins);
        c8sd_req_t b;
        b             = rand_beat();
        b.operation   = OP_EXEC;
        b.instruction = ins;
        return b;
    endfunction

    function automatic c8sd_req_t mk_row(input logic [ROW_W-1:0] row);
        c8sd_req_t b;
        b            = rand_beat();
        b.operation  = OP_ROW;
        b.row_select = row;
        return b;
    endfunction

    // Register for a sprite coordinate; VF now and then.
    function automatic int pick_reg();
        if ($urandom_range(0, 7) == 0)
            return REG_VF;
        return $urandom_range(0, 14);
    endfunction

    // Coordinate value, biased toward the right and bottom edges to hit clipping.
    function automatic logic [7:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(56, 63));
            1:       return 8'($urandom_range(24, 31));
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side: offer one beat, hold it until accepted, then log the
    // expected response and maybe drop valid for a while.
    // ------------------------------------------------------------------
    task automatic send_beat(input c8sd_req_t beat);
        int gap;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= beat;
        do @(posedge clk); while (!req_ch.ready);
        pending_rsp.push_back(chip8_predict(beat));
        beats_sent++;
        gap = idling_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid, then hold until every owed response is in, plus a margin
    // for the core to settle back to idle.
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp_req)
            begin
                hold_rsp_req = 1'b0;
                stall_left   = RSP_HOLD_CYCLES;
            end
            else if (stall_left == 0 && idling_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Compare every response beat, field by field, with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response beat with no request outstanding");
                mismatches++;
            end
            else
            begin
                rsp_want = pending_rsp.pop_front();
                rsp_got  = rsp_ch.data;
                if (rsp_got.pc_value !== rsp_want.pc_value)
                begin
                    $error("pc_value: expected %h, got %h",
                           rsp_want.pc_value, rsp_got.pc_value);
                    mismatches++;
                end
                if (rsp_got.index_value !== rsp_want.index_value)
                begin
                    $error("index_value: expected %h, got %h",
                           rsp_want.index_value, rsp_got.index_value);
                    mismatches++;
                end
                if (rsp_got.register_value !== rsp_want.register_value)
                begin
                    $error("register_value: expected %h, got %h",
                           rsp_want.register_value, rsp_got.register_value);
                    mismatches++;
                end
                if (rsp_got.collision !== rsp_want.collision)
                begin
                    $error("collision: expected %b, got %b",
                           rsp_want.collision, rsp_got.collision);
                    mismatches++;
                end
                if (rsp_got.unknown_opcode !== rsp_want.unknown_opcode)
                begin
                    $error("unknown_opcode: expected %b, got %b",
                           rsp_want.unknown_opcode, rsp_got.unknown_opcode);
                    mismatches++;
                end
                if (rsp_got.row_pixels !== rsp_want.row_pixels)
                begin
                    $error("row_pixels: expected %h, got %h",
                           rsp_want.row_pixels, rsp_got.row_pixels);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Display starts unlit; the ignored operation still reports pc, index, VF.
    task automatic test_reset_view();
        c8sd_req_t b;
        send_beat(mk_row('0));
        b           = rand_beat();
        b.operation = OP_IGNORED;
        send_beat(b);
    endtask

    // Set and add, including the 8-bit wrap, and VF as a plain register.
    task automatic test_register_ops();
        send_beat(mk_exec({OPC_SET, 4'h0, 8'hFF}));
        send_beat(mk_exec({OPC_ADD, 4'h0, 8'h01}));
        send_beat(mk_exec({OPC_ADD, 4'hE, 8'hFF}));
        send_beat(mk_exec({OPC_SET, REG_VF, 8'h01}));
    endtask

    task automatic test_jump_and_index();
        send_beat(mk_exec({OPC_JUMP, 12'h000}));
        send_beat(mk_exec({OPC_JUMP, 12'hFFF}));
        send_beat(mk_exec({OPC_INDEX, 12'h000}));
    endtask

    // Opcodes outside the subset, a system call other than clear among them.
    task automatic test_unknown_opcodes();
        send_beat(mk_exec({OPC_SYS, 12'h000}));
        send_beat(mk_exec(INS_RET));
        send_beat(mk_exec({OPC_SKIP_EQ_REG, 12'hAB0}));
        send_beat(mk_exec({OPC_MISC, 12'hFFF}));
    endtask

    // Sprite bytes straddle the end of memory and the sprite clips at the
    // bottom-right corner; the second draw erases it and reports a collision.
    task automatic test_draw_wrap_clip();
        send_beat(mk_load(12'hFFE, 8'hFF));
        send_beat(mk_load(12'hFFF, 8'hA5));
        send_beat(mk_load(12'h000, 8'h00));
        send_beat(mk_exec({OPC_INDEX, 12'hFFE}));
        send_beat(mk_exec({OPC_SET, 4'h1, 8'd62}));
        send_beat(mk_exec({OPC_SET, 4'h2, 8'd31}));
        send_beat(mk_exec({OPC_DRAW, 4'h1, 4'h2, 4'd3}));
        send_beat(mk_row(ROW_W'(SCREEN_HEIGHT - 1)));
        send_beat(mk_exec({OPC_DRAW, 4'h1, 4'h2, 4'd3}));
        send_beat(mk_row(ROW_W'(SCREEN_HEIGHT - 1)));
    endtask

    // Draw with both coordinates in VF, an empty draw, then clear.
    task automatic test_draw_vf_and_empty();
        send_beat(mk_exec({OPC_SET, REG_VF, 8'h05}));
        send_beat(mk_exec({OPC_DRAW, REG_VF, REG_VF, 4'd1}));
        send_beat(mk_row(ROW_W'(5)));
        send_beat(mk_exec({OPC_DRAW, 4'h1, 4'h2, 4'd0}));
        send_beat(mk_exec(INS_CLS));
        send_beat(mk_row(ROW_W'(5)));
    endtask

    // ------------------------------------------------------------------
    // Random tests
    // ------------------------------------------------------------------

    // One well-formed drawing sequence: load a sprite, point the index at it,
    // place it, draw, maybe draw again, read rows back.
    task automatic run_sprite_sequence();
        int                rows;
        int                pick;
        int                xr;
        int                yr;
        logic [ADDR_W-1:0] base;
        logic [15:0]       draw_ins;
        pick = $urandom_range(0, 99);
        rows = (pick < 5) ? 0 : ((pick < 25) ? 15 : $urandom_range(1, 8));
        pick = $urandom_range(0, 9);
        base = (pick < 3) ? ADDR_W'($urandom_range(4080, 4095)) : ADDR_W'($urandom);
        // Reuse the current sprite now and then, without reloading it.
        if (pick == 9)
        begin
            base = shadow_i;
        end
        else
        begin
            for (int k = 0; k < rows; k++)
            begin
                send_beat(mk_load(ADDR_W'(base + k),
                                  ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom)));
            end
        end
        send_beat(mk_exec({OPC_INDEX, base}));
        xr = pick_reg();
        yr = pick_reg();
        send_beat(mk_exec({OPC_SET, 4'(xr), pick_coord()}));
        if ($urandom_range(0, 3) == 0)
            send_beat(mk_exec({OPC_ADD, 4'(xr), 8'($urandom)}));
        send_beat(mk_exec({OPC_SET, 4'(yr), pick_coord()}));
        draw_ins = {OPC_DRAW, 4'(xr), 4'(yr), 4'(safe_rows(rows))};
        send_beat(mk_exec(draw_ins));
        if ($urandom_range(0, 2) == 0)
            send_beat(mk_exec(draw_ins));
        repeat ($urandom_range(1, 2))
        begin
            send_beat(mk_row(ROW_W'(shadow_v[yr] % SCREEN_HEIGHT + $urandom_range(0, 3))));
        end
    endtask

    // A few beats of any operation with random content; draws keep to
    // loaded memory.
    task automatic send_noise_burst();
        c8sd_req_t b;
        repeat ($urandom_range(1, 4))
        begin
            b = rand_beat();
            if (b.operation == OP_EXEC)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       b.instruction[15:12] = OPC_SYS;
                        1:       b.instruction[15:12] = OPC_JUMP;
                        2:       b.instruction[15:12] = OPC_SET;
                        3:       b.instruction[15:12] = OPC_ADD;
                        4:       b.instruction[15:12] = OPC_INDEX;
                        default: b.instruction[15:12] = OPC_DRAW;
                    endcase
                end
                if ($urandom_range(0, 19) == 0)
                    b.instruction = INS_CLS;
                if (b.instruction[15:12] == OPC_DRAW)
                    b.instruction[3:0] = 4'(safe_rows(b.instruction[3:0]));
            end
            send_beat(b);
        end
    endtask

    // Mix drawing sequences and noise until the beat count reaches target.
    task automatic test_random_programs(input int unsigned target);
        while (beats_sent < target)
        begin
            if ($urandom_range(0, 9) < 7)
                run_sprite_sequence();
            else
                send_noise_burst();
        end
    endtask

    // Hold the response side off for a long stretch while requests keep
    // coming, so the core backs up and stalls its input.
    task automatic test_output_backpressure();
        int unsigned stop_at;
        stop_at      = beats_sent + 30;
        hold_rsp_req = 1'b1;
        while (beats_sent < stop_at)
            run_sprite_sequence();
    endtask

    // Pause until the core is empty, then run a stretch with no idling.
    task automatic test_sender_pause();
        int unsigned stop_at;
        wait_drained();
        idling_on = 1'b0;
        stop_at   = beats_sent + 40;
        test_random_programs(stop_at);
        idling_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        for (int k = 0; k < MEM_BYTES; k++)
        begin
            shadow_mem[k] = '0;
            mem_loaded[k] = 1'b0;
        end
        for (int k = 0; k < NUM_REGS; k++)
        begin
            shadow_v[k] = '0;
        end
        for (int k = 0; k < SCREEN_HEIGHT; k++)
        begin
            shadow_fb[k] = '0;
        end
        shadow_i  = '0;
        shadow_pc = ADDR_W'(12'h200);

        // Hold reset, then release it away from the clock edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_view();
        test_register_ops();
        test_jump_and_index();
        test_unknown_opcodes();
        test_draw_wrap_clip();
        test_draw_vf_and_empty();
        test_random_programs(200);
        test_output_backpressure();
        test_sender_pause();
        test_random_programs(440);

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb_chip8_core_with_sprite_draw_core OK");
        else
            $display("tb_chip8_core_with_sprite_draw_core NOT OK");
        $finish;
    end

    // Give up if the run hangs.
    initial
    begin
        #10_000_000;
        $display("tb_chip8_core_with_sprite_draw_core NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/c8sd_pkg.sv
rtl/c8sd_if.sv
rtl/chip8_core_with_sprite_draw_core.sv
tb/tb_chip8_core_with_sprite_draw_core.sv
